### design/sra_pkg.sv
// ----------------------------------------------------------------------------
// sra_pkg
// Shared types and constants of the stacked region allocator table.
// ----------------------------------------------------------------------------
package sra_pkg;

  localparam int MaxEntries = 254;
  localparam int AlignSize  = 4096;
  localparam int IdxW       = 8;
  localparam int CntW       = 8;
  localparam logic [31:0] BlockMask = 32'(AlignSize - 1);

  typedef enum logic [1:0] {
    CMD_INIT   = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EXISTED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_NO_TABLE  = 3'd3,
    ST_LOCKED    = 3'd4,
    ST_FULL      = 3'd5,
    ST_TOO_LARGE = 3'd6,
    ST_NOT_LAST  = 3'd7
  } status_t;

  localparam logic [1:0] REG_TOP    = 2'd0;
  localparam logic [1:0] REG_LOCKED = 2'd1;
  localparam logic [1:0] REG_ROOT   = 2'd2;

  // Classified command handed from front to back.
  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] id;
    logic        too_large;
    logic [31:0] size;
    logic [IdxW-1:0] idx;
  } req_t;

endpackage

### design/sra_front.sv
// ----------------------------------------------------------------------------
// sra_front
// Accepts commands, pre-classifies size and queues them for the back end.
// ----------------------------------------------------------------------------
module sra_front import sra_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_region_id,
  input  logic [63:0] in_request_size,
  input  logic [7:0]  in_entry_index,
  output logic        q_valid,
  output req_t        q_data,
  input  logic        q_pop
);

  req_t q_mem_r [2];
  logic q_wp_r, q_rp_r;
  logic [1:0] q_cnt_r;
  req_t req;
  logic push;

  always_comb begin
    req.cmd       = cmd_t'(in_cmd);
    req.id        = in_region_id;
    req.too_large = |in_request_size[63:32];
    req.size      = (in_request_size[31:0] + BlockMask) & ~BlockMask;
    req.idx       = in_entry_index;
  end

  assign in_stall = (q_cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (q_cnt_r != 2'd0);
  assign q_data   = q_mem_r[q_rp_r];

  always_ff @(posedge clk) begin
    if (push) q_mem_r[q_wp_r] <= req;
    if (!rst_n) begin
      q_wp_r <= 1'b0;
      q_rp_r <= 1'b0;
      q_cnt_r <= 2'd0;
    end else begin
      if (push) q_wp_r <= ~q_wp_r;
      if (q_pop) q_rp_r <= ~q_rp_r;
      q_cnt_r <= q_cnt_r + 2'(push) - 2'(q_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= 2'd2) else $error("queue count out of range");
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (q_cnt_r == 2'd2 && !q_pop) |=> in_stall) else $error("full queue not stalled");

endmodule

### design/sra_back.sv
// ----------------------------------------------------------------------------
// sra_back
// Executes queued commands against the region table, scanning ids serially.
// ----------------------------------------------------------------------------
module sra_back import sra_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  req_t        q_data,
  output logic        q_pop,
  input  logic [31:0] top_address,
  input  logic        locked,
  input  logic [31:0] root_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_result_index,
  output logic [31:0] out_region_start,
  output logic [31:0] out_region_size,
  output logic [31:0] out_low_address
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_CMP  = 4'b0100,
    S_HIT  = 4'b1000
  } state_t;

  state_t state_r;
  logic [31:0] ids_mem   [MaxEntries];
  logic [31:0] starts_mem[MaxEntries];
  logic [31:0] sizes_mem [MaxEntries];

  logic [CntW-1:0] cnt_r;
  logic            present_r;
  logic [31:0]     root_base_r;
  logic [31:0]     last_start_r;   // start of the last entry in use
  logic [IdxW-1:0] scan_r;
  logic [31:0]     rd_id_r, rd_start_r, rd_size_r;
  req_t            cur_r;
  logic            ov_r;
  logic [2:0]      st_r;
  logic [7:0]      ri_r;
  logic [31:0]     rs_r, rz_r, la_r;

  logic [31:0] top, low;
  logic out_free;
  assign top = top_address & ~BlockMask;
  assign low = !present_r ? 32'd0 : (cnt_r != '0) ? last_start_r : root_base_r;
  assign out_free = !ov_r || !out_stall;
  assign q_pop = (state_r == S_IDLE) && q_valid && out_free;

  assign out_valid = ov_r;
  assign out_status = st_r;
  assign out_result_index = ri_r;
  assign out_region_start = rs_r;
  assign out_region_size = rz_r;
  assign out_low_address = la_r;

  // Memories: one write, one read per cycle.
  logic            we;
  logic [IdxW-1:0] wa;
  logic [31:0]     wid, wst, wsz;
  logic [IdxW-1:0] ra;
  always_ff @(posedge clk) begin
    if (we) begin
      ids_mem[wa] <= wid;
      starts_mem[wa] <= wst;
      sizes_mem[wa] <= wsz;
    end
    rd_id_r <= ids_mem[ra];
    rd_start_r <= starts_mem[ra];
    rd_size_r <= sizes_mem[ra];
  end

  logic scan_end;
  assign scan_end = (CntW'(scan_r) + 1'b1 >= cnt_r);

  always_comb begin
    we = 1'b0; wa = cnt_r[IdxW-1:0]; wid = cur_r.id;
    wst = low - cur_r.size; wsz = cur_r.size;
    ra = scan_r;
    if (state_r == S_IDLE && q_pop && q_data.cmd == CMD_INIT && top != 0) begin
      we = 1'b1; wa = '0; wid = root_id;
      wst = (top - 32'(AlignSize)) & ~BlockMask;
      wsz = top - wst;
    end
    // add into an empty table needs no scan
    if (state_r == S_IDLE && q_pop && q_data.cmd == CMD_ADD && present_r &&
        cnt_r == '0 && !q_data.too_large && !locked) begin
      we = 1'b1; wa = '0; wid = q_data.id;
      wst = low - q_data.size; wsz = q_data.size;
    end
    if (state_r == S_CMP && rd_id_r != cur_r.id && scan_end &&
        cur_r.cmd == CMD_ADD && !cur_r.too_large && !locked &&
        cnt_r < CntW'(MaxEntries))
      we = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      present_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (ov_r && !out_stall) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            cur_r <= q_data;
            scan_r <= '0;
            ri_r <= '0; rs_r <= '0; rz_r <= '0;
            st_r <= ST_OK;
            case (q_data.cmd)
              CMD_INIT: begin
                ov_r <= 1'b1;
                if (top == 0) begin
                  st_r <= ST_NO_TABLE; la_r <= low;
                end else begin
                  present_r <= 1'b1;
                  cnt_r <= CntW'(1);
                  root_base_r <= wst;
                  last_start_r <= wst;
                  la_r <= wst;
                end
              end
              CMD_REMOVE: begin
                ov_r <= 1'b1;
                la_r <= low;
                if (!present_r) st_r <= ST_NO_TABLE;
                else if (cnt_r == '0) st_r <= ST_NOT_FOUND;
                else if (locked) st_r <= ST_LOCKED;
                else if (CntW'(q_data.idx) != cnt_r - 1'b1) st_r <= ST_NOT_LAST;
                else begin
                  cnt_r <= cnt_r - 1'b1;
                  // pick up the new last start from memory
                  if (cnt_r == CntW'(1)) la_r <= root_base_r;
                  else begin
                    ov_r <= 1'b0;
                    scan_r <= IdxW'(cnt_r - CntW'(2));
                    state_r <= S_HIT;
                  end
                end
              end
              default: begin
                if (present_r && cnt_r != '0) state_r <= S_RD;
                else begin
                  ov_r <= 1'b1;
                  la_r <= low;
                  if (q_data.cmd == CMD_FIND)
                    st_r <= present_r ? ST_NOT_FOUND : ST_NO_TABLE;
                  else if (q_data.too_large) st_r <= ST_TOO_LARGE;
                  else if (!present_r) st_r <= ST_NO_TABLE;
                  else if (locked) st_r <= ST_LOCKED;
                  else begin
                    ri_r <= 8'(cnt_r); rs_r <= wst;
                    rz_r <= q_data.size;
                    la_r <= wst; last_start_r <= wst;
                    cnt_r <= cnt_r + 1'b1;
                  end
                end
              end
            endcase
          end
        end
        S_RD: begin
          if (cur_r.cmd == CMD_REMOVE) begin
            state_r <= S_IDLE;
            ov_r <= 1'b1;
            la_r <= rd_start_r;
            last_start_r <= rd_start_r;
          end else begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          if (rd_id_r == cur_r.id) begin
            ov_r <= 1'b1; la_r <= low;
            st_r <= (cur_r.cmd == CMD_ADD) ? ST_EXISTED : ST_OK;
            ri_r <= 8'(scan_r); rs_r <= rd_start_r; rz_r <= rd_size_r;
            state_r <= S_IDLE;
          end else if (scan_end) begin
            ov_r <= 1'b1; la_r <= low;
            state_r <= S_IDLE;
            if (cur_r.cmd == CMD_FIND) st_r <= ST_NOT_FOUND;
            else if (cur_r.too_large) st_r <= ST_TOO_LARGE;
            else if (locked) st_r <= ST_LOCKED;
            else if (cnt_r >= CntW'(MaxEntries)) st_r <= ST_FULL;
            else begin
              ri_r <= 8'(cnt_r); rs_r <= wst; rz_r <= cur_r.size;
              la_r <= wst; last_start_r <= wst;
              cnt_r <= cnt_r + 1'b1;
            end
          end else begin
            scan_r <= scan_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_HIT: begin
          // read of the new last start is issued now; data lands in S_RD
          state_r <= S_RD;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_busy_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !q_pop) else $error("pop while busy");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(MaxEntries)) else $error("entry count overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |=> (ov_r && $stable(st_r) && $stable(la_r)))
    else $error("result changed while stalled");

endmodule

### design/stacked_region_allocator_table_core.sv
// ----------------------------------------------------------------------------
// stacked_region_allocator_table_core
// Region table growing downward from a configured top address.
// ----------------------------------------------------------------------------
// channel  direction  handshake          payload
// in       input      in_valid/in_stall  cmd, region_id, request_size, entry_index
// out      output     out_valid/out_stall status, index, start, size, low address
// cfg      input      cfg_we             cfg_index, cfg_data
// Init completes from idle; a remove above the root entry reads the new last
// start via S_HIT, S_RD; add and find scan via S_RD, S_CMP on one read port.
// Reset (rst_n low, synchronous) empties the table and queue; no clearing pass.
// A stalled result holds; the two-entry queue keeps taking commands until full.
module stacked_region_allocator_table_core import sra_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_region_id,
  input  logic [63:0] in_request_size,
  input  logic [7:0]  in_entry_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_result_index,
  output logic [31:0] out_region_start,
  output logic [31:0] out_region_size,
  output logic [31:0] out_low_address,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] top_r, root_r;
  logic locked_r;
  logic q_valid, q_pop;
  req_t q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= '0; locked_r <= 1'b0; root_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TOP:    top_r <= cfg_data;
        REG_LOCKED: locked_r <= cfg_data[0];
        REG_ROOT:   root_r <= cfg_data;
        default: ;
      endcase
    end
  end

  sra_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_cmd, .in_region_id,
    .in_request_size, .in_entry_index, .q_valid, .q_data, .q_pop
  );

  sra_back u_back (
    .clk, .rst_n, .q_valid, .q_data, .q_pop,
    .top_address(top_r), .locked(locked_r), .root_id(root_r),
    .out_valid, .out_stall, .out_status, .out_result_index,
    .out_region_start, .out_region_size, .out_low_address
  );

endmodule
